// ===== rtl/wbps_pkg.sv =====
// shared types and constants for the wildcard byte pattern search
`timescale 1ns / 1ps

package wbps_pkg;

   // default and fixed widths
   localparam int MAX_BYTES_DEFAULT = 16;
   localparam int BYTE_W = 8;
   localparam int ADDR_W = 48;
   localparam int LEN_W = 5;
   localparam int REG_W = 64;
   localparam int CARE_W = 16;
   localparam int CSR_IDX_W = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LOW = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CARE_MASK = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDRESS = 3'd4;

   // register file contents as seen by the datapath
   typedef struct packed {
      logic [REG_W-1:0]  pattern_low;
      logic [REG_W-1:0]  pattern_high;
      logic [CARE_W-1:0] care_mask;
      logic [LEN_W-1:0]  pattern_length;
      logic [ADDR_W-1:0] base_address;
   } cfg_type;

endpackage

// ===== rtl/wbps_regs.sv =====
// configuration registers of the wildcard byte pattern search
`timescale 1ns / 1ps

module wbps_regs
   import wbps_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PATTERN_LOW:    cfg_in.pattern_low = csr_wdata;
            CSR_PATTERN_HIGH:   cfg_in.pattern_high = csr_wdata;
            CSR_CARE_MASK:      cfg_in.care_mask = csr_wdata[CARE_W-1:0];
            CSR_PATTERN_LENGTH: cfg_in.pattern_length = csr_wdata[LEN_W-1:0];
            CSR_BASE_ADDRESS:   cfg_in.base_address = csr_wdata[ADDR_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_low <= '0;
         cfg_ff.pattern_high <= '0;
         cfg_ff.care_mask <= '0;
         cfg_ff.pattern_length <= LEN_W'(1);
         cfg_ff.base_address <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/wbps_cell.sv =====
// one window cell: holds one image byte and checks its input byte against its pattern byte
`timescale 1ns / 1ps

module wbps_cell
   import wbps_pkg::*;
#(
   parameter int MAX_BYTES = MAX_BYTES_DEFAULT,
   parameter int POSITION = 0,
   localparam int IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            shift,
   input  logic                            clear,
   input  logic [BYTE_W-1:0]               d_in,
   input  logic [MAX_BYTES-1:0][BYTE_W-1:0] pattern,
   input  logic [MAX_BYTES-1:0]            care,
   input  logic [LEN_W-1:0]                len,
   output logic [BYTE_W-1:0]               q_out,
   output logic                            hit
);

   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in;
   logic [LEN_W-1:0]  idx_full;
   logic [IDX_W-1:0]  idx;
   logic              in_window;

   // the byte seen here sits POSITION bytes back, so it pairs with
   // pattern byte len - 1 - POSITION
   assign in_window = len > LEN_W'(POSITION);
   assign idx_full = len - LEN_W'(POSITION + 1);
   assign idx = idx_full[IDX_W-1:0];
   assign hit = !in_window || !care[idx] || (d_in == pattern[idx]);

   // shift the byte on toward the older cells, or clear it at the end of an image
   always_comb begin
      byte_in = byte_ff;
      if (clear) begin
         byte_in = '0;
      end else if (shift) begin
         byte_in = d_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
      end else begin
         byte_ff <= byte_in;
      end
   end

   assign q_out = byte_ff;

endmodule

// ===== rtl/wildcard_byte_pattern_search.sv =====
// top level of the wildcard byte pattern search
`timescale 1ns / 1ps
// a result transfer is registered and offered in the cycle after the byte that causes it
// throughput: one image byte per cycle while not stalled, set by the row of
// window cells that compares every pattern byte in parallel while the bytes shift on
// an output register decouples the result side; input stalls while it is full and not taken
// reset (synchronous, active high) clears the window, position, report flag and
// output valid and resets the configuration registers; there is no clearing pass

module wildcard_byte_pattern_search
   import wbps_pkg::*;
#(
   parameter int MAX_BYTES = MAX_BYTES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   // input channel, tdata: image_byte [7:0]; tlast: last_byte
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [BYTE_W-1:0]    req_tdata,
   input  logic                 req_tlast,
   // result channel, tdata: match_address [47:0]; tuser: found
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [ADDR_W-1:0]    rsp_tdata,
   output logic                 rsp_tuser,
   // configuration write port
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_wdata
);

   cfg_type cfg;

   logic [MAX_BYTES-1:0][BYTE_W-1:0] pat_bytes;
   logic [MAX_BYTES:0][BYTE_W-1:0]   byte_chain;
   logic [MAX_BYTES-1:0]             hits;
   logic [LEN_W-1:0]                 used_len;
   logic [LEN_W-1:0]                 len_m1;

   logic [ADDR_W-1:0] pos_ff;
   logic [ADDR_W-1:0] pos_in;
   logic              reported_ff;
   logic              reported_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              found_ff;
   logic              found_in;
   logic [ADDR_W-1:0] addr_ff;
   logic [ADDR_W-1:0] addr_in;

   logic              accept;
   logic              pos_ok;
   logic              match;
   logic              result_valid;
   logic [ADDR_W-1:0] match_addr;

   wbps_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // length in use, clamped to one through the window size
   always_comb begin
      used_len = cfg.pattern_length;
      if (cfg.pattern_length == '0) begin
         used_len = LEN_W'(1);
      end else if (cfg.pattern_length > LEN_W'(MAX_BYTES)) begin
         used_len = LEN_W'(MAX_BYTES);
      end
   end
   assign len_m1 = used_len - LEN_W'(1);

   // pattern bytes as an array
   for (genvar i = 0; i < MAX_BYTES; i++) begin : g_pat
      if (i < 8) begin : g_low
         assign pat_bytes[i] = cfg.pattern_low[BYTE_W*i +: BYTE_W];
      end else begin : g_high
         assign pat_bytes[i] = cfg.pattern_high[BYTE_W*(i-8) +: BYTE_W];
      end
   end

   assign accept = req_tvalid && req_tready;
   assign byte_chain[0] = req_tdata;

   // row of window cells, the current byte enters cell zero
   for (genvar k = 0; k < MAX_BYTES; k++) begin : g_cell
      wbps_cell #(
         .MAX_BYTES (MAX_BYTES),
         .POSITION  (k)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .shift   (accept && !req_tlast),
         .clear   (accept && req_tlast),
         .d_in    (byte_chain[k]),
         .pattern (pat_bytes),
         .care    (cfg.care_mask[MAX_BYTES-1:0]),
         .len     (used_len),
         .q_out   (byte_chain[k+1]),
         .hit     (hits[k])
      );
   end

   // match decision and start address
   assign pos_ok = pos_ff >= ADDR_W'(len_m1);
   assign match = !reported_ff && pos_ok && (&hits);
   assign match_addr = cfg.base_address + pos_ff - ADDR_W'(len_m1);
   assign result_valid = match || (req_tlast && !reported_ff);

   // position and report flag, cleared at the end of each image
   always_comb begin
      pos_in = pos_ff;
      reported_in = reported_ff;
      if (accept) begin
         if (req_tlast) begin
            pos_in = '0;
            reported_in = 1'b0;
         end else begin
            pos_in = pos_ff + ADDR_W'(1);
            reported_in = reported_ff || match;
         end
      end
   end

   // output register
   assign req_tready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      found_in = found_ff;
      addr_in = addr_ff;
      if (accept && result_valid) begin
         rsp_valid_in = 1'b1;
         found_in = match;
         addr_in = match ? match_addr : '0;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         reported_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         reported_ff <= reported_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
      addr_ff <= addr_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = addr_ff;
   assign rsp_tuser = found_ff;

endmodule
